// ===== hdl/mmrp_pkg.sv =====
// Shared types and constants for the memory map / ROM protect block.
package mmrp_pkg;

  localparam int DATA_W   = 8;
  localparam int ADDR_W   = 16;
  localparam int RDATA_W  = 16;
  localparam int HIT_W    = 2;
  localparam int CMD_W    = 3;
  localparam int REGIDX_W = 3;

  localparam logic [ADDR_W:0] GRAPH_WINDOW = 17'd16;
  localparam logic [ADDR_W:0] CHARIO_WINDOW = 17'd2;

  localparam logic [CMD_W-1:0] CMD_RD_BYTE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RD_WORD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_BYTE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_IMG_RD  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_IMG_WR  = 3'd4;

  localparam logic [HIT_W-1:0] HIT_MEM    = 2'd0;
  localparam logic [HIT_W-1:0] HIT_CHARIO = 2'd1;
  localparam logic [HIT_W-1:0] HIT_GRAPH  = 2'd2;

  localparam logic [REGIDX_W-1:0] REG_ROM_EN    = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_ROM_BEGIN = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_ROM_END   = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_CHR_EN    = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_CHR_BASE  = 3'd4;
  localparam logic [REGIDX_W-1:0] REG_GFX_EN    = 3'd5;
  localparam logic [REGIDX_W-1:0] REG_GFX_BASE  = 3'd6;

  localparam logic [ADDR_W-1:0] RST_ROM_BEGIN = 16'hD000;
  localparam logic [ADDR_W-1:0] RST_ROM_END   = 16'hDFFF;
  localparam logic [ADDR_W-1:0] RST_CHR_BASE  = 16'hE000;
  localparam logic [ADDR_W-1:0] RST_GFX_BASE  = 16'hE100;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_SLOT  = 7'b0001000,
    ST_RD0   = 7'b0010000,
    ST_RD1   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

endpackage

// ===== hdl/memory_map_rom_protect_core.sv =====
// Top level: byte memory image with bus decode and ROM write protection.
// Usage: each input beat carries a command (bus read byte, bus read word,
// bus write byte, image read, image write), an address and a write byte.
// Exactly one result beat follows each input beat, in order: read data,
// the device window that was hit and the ROM-blocked flag.
// Sequence: after the input beat the block steps through a multiply state,
// a slot state, one image read (two for word reads; none for writes and
// unknown commands) and a finish state; the block takes one beat at a time.
// The pace is set by the single-port image memory (one access a cycle,
// registered read data) and the two-step multiply that reduces an address
// modulo MEM_BYTES.
// Reset: configuration registers take their reset values and the image is
// swept to zero, one byte a cycle, through every slot; in_tready stays
// low meanwhile. Configuration writes are taken at any time.
// Stall: a finished result sits in the output register; the next beat is
// accepted meanwhile, and its result waits until the register frees.
module memory_map_rom_protect_core #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // command[2:0], address[18:3], write_data[26:19]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // read_data[15:0], device_hit[17:16], write_blocked[18]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int QW = 17 - AW;
  localparam logic [47:0] RECIP = 48'((64'd1 << 32) / MEM_BYTES);
  localparam logic [16:0] MEM_N = 17'(MEM_BYTES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MEM_BYTES - 1);

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wd;

  mmrp_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;

  logic        rom_en_r, chr_en_r, gfx_en_r;
  logic [15:0] rom_begin_r, rom_end_r, chr_base_r, gfx_base_r;

  logic [2:0]    cmd_r;
  logic [15:0]   addr_r;
  logic [7:0]    wdata_r;
  logic [1:0]    hit_r;
  logic          blk_r;
  logic [QW-1:0] q_r;
  logic [15:0]   qm_r;
  logic [AW-1:0] s1_r;
  logic [15:0]   rd_r;

  logic        out_valid_r;
  logic [15:0] out_rd_r;
  logic [1:0]  out_hit_r;
  logic        out_blk_r;

  logic [2:0]    in_cmd;
  logic [15:0]   in_addr;
  logic [7:0]    in_wdata;
  logic          in_fire;
  logic          is_bus;
  logic          chr_hit, gfx_hit;
  logic [15:0]   chr_off, gfx_off;
  logic [1:0]    hit_c;
  logic          blk_c;
  logic [47:0]   prod;
  logic [15:0]   rem0, rem1;
  logic [AW-1:0] s0, s1;
  logic          cfg_wr;
  logic          fin_go;

  assign in_cmd   = in_tdata[2:0];
  assign in_addr  = in_tdata[18:3];
  assign in_wdata = in_tdata[26:19];
  assign in_tready = (state_r == mmrp_pkg::ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;

  assign is_bus  = (in_cmd == mmrp_pkg::CMD_RD_BYTE) || (in_cmd == mmrp_pkg::CMD_RD_WORD) ||
                   (in_cmd == mmrp_pkg::CMD_WR_BYTE);
  assign chr_off = in_addr - chr_base_r;
  assign gfx_off = in_addr - gfx_base_r;
  assign chr_hit = chr_en_r && ({1'b0, chr_off} < mmrp_pkg::CHARIO_WINDOW);
  assign gfx_hit = gfx_en_r && ({1'b0, gfx_off} < mmrp_pkg::GRAPH_WINDOW);

  always_comb begin
    if (!is_bus) begin
      hit_c = mmrp_pkg::HIT_MEM;
    end else if (chr_hit) begin
      hit_c = mmrp_pkg::HIT_CHARIO;
    end else if (gfx_hit) begin
      hit_c = mmrp_pkg::HIT_GRAPH;
    end else begin
      hit_c = mmrp_pkg::HIT_MEM;
    end
  end

  assign blk_c = (in_cmd == mmrp_pkg::CMD_WR_BYTE) && rom_en_r &&
                 (in_addr >= rom_begin_r) && (in_addr <= rom_end_r);

  // address modulo MEM_BYTES: reciprocal multiply, back-multiply, one correction
  assign prod = 48'(in_addr) * RECIP;
  assign rem0 = addr_r - qm_r;
  assign rem1 = ({1'b0, rem0} >= MEM_N) ? 16'(17'(rem0) - MEM_N) : rem0;
  assign s0   = AW'(rem1);
  assign s1   = ((addr_r == 16'hFFFF) || (s0 == LAST_SLOT)) ? '0 : AW'(s0 + 1'b1);

  assign fin_go = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mmrp_pkg::ST_CLEAR: if (clr_cnt_r == LAST_SLOT) state_nxt = mmrp_pkg::ST_IDLE;
      mmrp_pkg::ST_IDLE:  if (in_fire) state_nxt = mmrp_pkg::ST_MUL;
      mmrp_pkg::ST_MUL:   state_nxt = mmrp_pkg::ST_SLOT;
      mmrp_pkg::ST_SLOT: begin
        case (cmd_r) inside
          mmrp_pkg::CMD_RD_BYTE, mmrp_pkg::CMD_RD_WORD, mmrp_pkg::CMD_IMG_RD:
            state_nxt = mmrp_pkg::ST_RD0;
          default: state_nxt = mmrp_pkg::ST_FIN;
        endcase
      end
      mmrp_pkg::ST_RD0: begin
        state_nxt = (cmd_r == mmrp_pkg::CMD_RD_WORD) ? mmrp_pkg::ST_RD1 : mmrp_pkg::ST_FIN;
      end
      mmrp_pkg::ST_RD1:   state_nxt = mmrp_pkg::ST_FIN;
      mmrp_pkg::ST_FIN:   if (fin_go) state_nxt = mmrp_pkg::ST_IDLE;
      default:            state_nxt = mmrp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we   = 1'b0;
    mem_addr = s0;
    mem_wd   = wdata_r;
    unique case (state_r)
      mmrp_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
        mem_wd   = '0;
      end
      mmrp_pkg::ST_SLOT: begin
        mem_we = ((cmd_r == mmrp_pkg::CMD_WR_BYTE) && !blk_r) ||
                 (cmd_r == mmrp_pkg::CMD_IMG_WR);
      end
      mmrp_pkg::ST_RD0: mem_addr = s1_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_q_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mmrp_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == mmrp_pkg::ST_CLEAR) begin
        clr_cnt_r <= AW'(clr_cnt_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_addr;
      wdata_r <= in_wdata;
      hit_r   <= hit_c;
      blk_r   <= blk_c;
      q_r     <= QW'(prod >> 32);
      rd_r    <= '0;
    end
    if (state_r == mmrp_pkg::ST_MUL) begin
      qm_r <= 16'(33'(q_r) * 33'(MEM_N));
    end
    if (state_r == mmrp_pkg::ST_SLOT) begin
      s1_r <= s1;
    end
    if (state_r == mmrp_pkg::ST_RD0) begin
      rd_r[7:0] <= mem_q_r;
    end
    if (state_r == mmrp_pkg::ST_RD1) begin
      rd_r[15:8] <= mem_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == mmrp_pkg::ST_FIN) && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == mmrp_pkg::ST_FIN) && fin_go) begin
      out_rd_r  <= rd_r;
      out_hit_r <= hit_r;
      out_blk_r <= blk_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_blk_r, out_hit_r, out_rd_r};

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_en_r    <= 1'b0;
      rom_begin_r <= mmrp_pkg::RST_ROM_BEGIN;
      rom_end_r   <= mmrp_pkg::RST_ROM_END;
      chr_en_r    <= 1'b0;
      chr_base_r  <= mmrp_pkg::RST_CHR_BASE;
      gfx_en_r    <= 1'b0;
      gfx_base_r  <= mmrp_pkg::RST_GFX_BASE;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        mmrp_pkg::REG_ROM_EN:    rom_en_r    <= cfg_pwdata[0];
        mmrp_pkg::REG_ROM_BEGIN: rom_begin_r <= cfg_pwdata[15:0];
        mmrp_pkg::REG_ROM_END:   rom_end_r   <= cfg_pwdata[15:0];
        mmrp_pkg::REG_CHR_EN:    chr_en_r    <= cfg_pwdata[0];
        mmrp_pkg::REG_CHR_BASE:  chr_base_r  <= cfg_pwdata[15:0];
        mmrp_pkg::REG_GFX_EN:    gfx_en_r    <= cfg_pwdata[0];
        mmrp_pkg::REG_GFX_BASE:  gfx_base_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      mmrp_pkg::REG_ROM_EN:    cfg_prdata = {31'd0, rom_en_r};
      mmrp_pkg::REG_ROM_BEGIN: cfg_prdata = {16'd0, rom_begin_r};
      mmrp_pkg::REG_ROM_END:   cfg_prdata = {16'd0, rom_end_r};
      mmrp_pkg::REG_CHR_EN:    cfg_prdata = {31'd0, chr_en_r};
      mmrp_pkg::REG_CHR_BASE:  cfg_prdata = {16'd0, chr_base_r};
      mmrp_pkg::REG_GFX_EN:    cfg_prdata = {31'd0, gfx_en_r};
      mmrp_pkg::REG_GFX_BASE:  cfg_prdata = {16'd0, gfx_base_r};
      default:                 cfg_prdata = '0;
    endcase
  end

endmodule
